[sv/assert_macros.svh]
// Assertion macros used by the checker file of this block.
// Needs nothing else; take it in with an include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while the reset is low.
`define ASSERT_RST(lbl, clk_sig, rst_sig, prop) \
    lbl: assert property (@(posedge clk_sig) disable iff (!(rst_sig)) (prop)) \
        else $error("assertion failed under reset guard");

// Concurrent assertion that is checked at every edge, reset included.
`define ASSERT_ALWAYS(lbl, clk_sig, prop) \
    lbl: assert property (@(posedge clk_sig) (prop)) \
        else $error("assertion failed");

`endif

[sv/irpz_pkg.sv]
// Package of the IR PWM zoom interpolator: beat payload types, register
// indexes, field widths and the duty saturation helper. Depends on nothing.
package irpz_pkg;

    localparam int RATIO_W = 16;
    localparam int DUTY_W = 7;
    localparam int IDX_W = 4;
    localparam int PCOUNT_W = 5;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 7;

    // Interpolation datapath: numerator, dividend, divisor and quotient widths.
    localparam int NUM_W = 24;
    localparam int DVD_W = 25;
    localparam int DVS_W = 17;
    localparam int QUO_W = 7;
    localparam int CNT_W = 3;

    localparam logic [DUTY_W-1:0] DUTY_MAX = 7'd100;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_NIGHT_ENABLE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_FOLLOW_ENABLE = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FOLLOW_ACTIVE = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MANUAL_VALID = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MANUAL_NEAR = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MANUAL_FAR = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND = 4'd7;

    typedef struct packed {
        logic                kind;
        logic [IDX_W-1:0]    entry_index;
        logic [RATIO_W-1:0]  entry_ratio;
        logic [DUTY_W-1:0]   entry_near;
        logic [DUTY_W-1:0]   entry_far;
        logic [RATIO_W-1:0]  zoom_ratio;
        logic [DUTY_W-1:0]   current_near;
        logic [DUTY_W-1:0]   current_far;
    } item_t;

    typedef struct packed {
        logic [DUTY_W-1:0] near_duty;
        logic [DUTY_W-1:0] far_duty;
        logic              near_update;
        logic              far_update;
    } result_t;

    // One breakpoint as held in the table memory.
    typedef struct packed {
        logic [RATIO_W-1:0] ratio;
        logic [DUTY_W-1:0]  near;
        logic [DUTY_W-1:0]  far;
    } point_t;

    function automatic logic [DUTY_W-1:0] sat_duty(input logic [DUTY_W-1:0] v);
        return (v > DUTY_MAX) ? DUTY_MAX : v;
    endfunction

endpackage

[sv/irpz_if.sv]
// Channel interfaces of the IR PWM zoom interpolator: item, result and
// configuration write. Depends on irpz_pkg for the payload types.
interface irpz_item_if;
    logic                 valid;
    logic                 ready;
    irpz_pkg::item_t      data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface irpz_result_if;
    logic                 valid;
    logic                 ready;
    irpz_pkg::result_t    data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface irpz_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [irpz_pkg::CFG_IDX_W-1:0]      index;
    logic [irpz_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[sv/irpz_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module irpz_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 16,
    parameter int ADDR_W = 4
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/irpz_div.sv]
// Restoring divider that yields one quotient bit per cycle for the
// rounded interpolation. Depends on irpz_pkg for the datapath widths.
module irpz_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [irpz_pkg::DVD_W-1:0]    dividend,
    input  logic [irpz_pkg::DVS_W-1:0]    divisor,
    output logic [irpz_pkg::QUO_W-1:0]    quotient,
    output logic                          done
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [irpz_pkg::CNT_W-1:0]    cnt_reg;
    logic [irpz_pkg::DVD_W-1:0]    rem_reg;
    logic [irpz_pkg::DVD_W-1:0]    rem_next;
    logic [irpz_pkg::DVD_W-1:0]    dsh_reg;
    logic [irpz_pkg::QUO_W-1:0]    quo_reg;
    logic [irpz_pkg::QUO_W-1:0]    quo_next;
    logic                          fits;

    // The quotient is known to stay below 2**QUO_W, so the divisor starts
    // aligned with the top quotient bit and moves down one place per step.
    assign fits = (rem_reg >= dsh_reg);
    assign rem_next = fits ? (rem_reg - dsh_reg) : rem_reg;
    assign quo_next = {quo_reg[irpz_pkg::QUO_W-2:0], fits};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= irpz_pkg::CNT_W'(irpz_pkg::QUO_W - 1);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend;
            dsh_reg <= irpz_pkg::DVD_W'(divisor) << (irpz_pkg::QUO_W - 1);
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dsh_reg <= dsh_reg >> 1;
            quo_reg <= quo_next;
        end
    end

    assign quotient = quo_reg;
    assign done = done_reg;

endmodule

[sv/ir_pwm_zoom_interpolator.sv]
// IR PWM zoom interpolator, top level. Depends on irpz_pkg, the channel
// interfaces in irpz_if, irpz_ram and irpz_div.
//
// Use: the item channel carries two kinds of beat. A table write (kind 0)
// stores one breakpoint (zoom ratio and near/far duty) in the slot given by
// entry_index and yields no result. A query
// (kind 1) carries a zoom ratio and the duties now applied and yields one
// result beat with the desired near/far duties and their update flags.
// The configuration channel writes one register per beat and is always
// ready; the user must write it only while no query is in flight, which
// the block does not enforce. A query that needs no table lookup (night
// off, no table use or an empty table) goes straight to the output stage.
// A lookup reads the table one breakpoint per cycle through the single
// read port of the table memory, then forms the products and runs the two
// bit-serial dividers before the output stage.
// One query is worked on at a time; the next item is taken as soon as the
// result sits in the output register, even if the receiver still stalls it.
// Reset sets the control and configuration registers to defaults and the
// result channel to idle; the table contents are undefined until written.
module ir_pwm_zoom_interpolator #(
    parameter int MAX_POINTS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    irpz_item_if.sink              item,
    irpz_result_if.source          result,
    irpz_cfg_if.sink               cfg
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_RD0    = 7'b0000010,
        S_RDLAST = 7'b0000100,
        S_SCAN   = 7'b0001000,
        S_MUL    = 7'b0010000,
        S_DIV    = 7'b0100000,
        S_EMIT   = 7'b1000000
    } state_t;

    // Configuration registers.
    logic                               night_reg;
    logic                               auto_reg;
    logic                               follow_reg;
    logic                               manual_reg;
    logic [irpz_pkg::DUTY_W-1:0]        man_near_reg;
    logic [irpz_pkg::DUTY_W-1:0]        man_far_reg;
    logic [irpz_pkg::PCOUNT_W-1:0]      pcount_reg;
    logic [irpz_pkg::DUTY_W-1:0]        deadband_reg;

    // Control.
    state_t                             state_reg;
    state_t                             state_next;
    logic [AW-1:0]                      idx_reg;
    logic [AW-1:0]                      idx_next;
    logic                               out_valid_reg;
    logic                               out_valid_next;

    // Payload.
    logic [irpz_pkg::RATIO_W-1:0]       z_reg;
    logic [irpz_pkg::RATIO_W-1:0]       z_next;
    logic [irpz_pkg::DUTY_W-1:0]        cur_near_reg;
    logic [irpz_pkg::DUTY_W-1:0]        cur_near_next;
    logic [irpz_pkg::DUTY_W-1:0]        cur_far_reg;
    logic [irpz_pkg::DUTY_W-1:0]        cur_far_next;
    irpz_pkg::point_t                   prev_reg;
    irpz_pkg::point_t                   prev_next;
    irpz_pkg::point_t                   hi_reg;
    irpz_pkg::point_t                   hi_next;
    logic [irpz_pkg::DUTY_W-1:0]        res_near_reg;
    logic [irpz_pkg::DUTY_W-1:0]        res_near_next;
    logic [irpz_pkg::DUTY_W-1:0]        res_far_reg;
    logic [irpz_pkg::DUTY_W-1:0]        res_far_next;
    irpz_pkg::result_t                  out_data_reg;
    irpz_pkg::result_t                  out_data_next;

    // Handshakes and derived control.
    logic                               item_acc;
    logic                               is_query;
    logic                               use_table;
    logic                               out_load;
    logic [CW-1:0]                      n_eff;
    logic [AW-1:0]                      last_idx;

    // Table memory.
    logic                               ram_we;
    logic [AW-1:0]                      ram_waddr;
    irpz_pkg::point_t                   ram_wdata;
    logic [AW-1:0]                      ram_raddr;
    logic [$bits(irpz_pkg::point_t)-1:0] ram_rdata;
    irpz_pkg::point_t                   ram_pt;

    // Segment arithmetic.
    logic [irpz_pkg::RATIO_W-1:0]       seg_den;
    logic [irpz_pkg::RATIO_W-1:0]       seg_off;
    logic [irpz_pkg::RATIO_W-1:0]       seg_rest;
    logic                               seg_flat;
    logic [irpz_pkg::NUM_W-1:0]         num_near;
    logic [irpz_pkg::NUM_W-1:0]         num_far;
    logic [irpz_pkg::DVD_W-1:0]         dvd_near;
    logic [irpz_pkg::DVD_W-1:0]         dvd_far;
    logic [irpz_pkg::DVS_W-1:0]         dvs;
    logic                               div_start;
    logic [irpz_pkg::QUO_W-1:0]         quo_near;
    logic [irpz_pkg::QUO_W-1:0]         quo_far;
    logic                               div_done_near;
    logic                               div_done_far;

    // Deadband test.
    logic [irpz_pkg::DUTY_W-1:0]        diff_near;
    logic [irpz_pkg::DUTY_W-1:0]        diff_far;

    assign item_acc = item.valid && item.ready;
    assign item.ready = (state_reg == S_IDLE);
    assign is_query = (item.data.kind == irpz_pkg::KIND_QUERY);

    // Priority: night off gives zero, follow with auto follow interpolates,
    // a manual setting comes next, auto follow alone interpolates last.
    assign use_table = auto_reg && (follow_reg || !manual_reg);

    // A point count above the table depth saturates to the depth.
    assign n_eff = (32'(pcount_reg) > 32'(MAX_POINTS)) ? CW'(MAX_POINTS) : CW'(pcount_reg);
    assign last_idx = AW'(32'(n_eff) - 32'd1);

    assign cfg.ready = 1'b1;

    // Table writes happen in the cycle the write beat is taken; slots past
    // the table depth are dropped.
    assign ram_we = item_acc && (item.data.kind == irpz_pkg::KIND_WRITE)
                    && (32'(item.data.entry_index) < 32'(MAX_POINTS));
    assign ram_waddr = AW'(32'(item.data.entry_index));
    assign ram_wdata = '{ratio: item.data.entry_ratio,
                         near: item.data.entry_near,
                         far: item.data.entry_far};
    assign ram_pt = irpz_pkg::point_t'(ram_rdata);

    irpz_ram #(
        .WIDTH  ($bits(irpz_pkg::point_t)),
        .DEPTH  (MAX_POINTS),
        .ADDR_W (AW)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // The lerp is written as dl*(den-off) + dr*off over den, which keeps
    // every term non-negative. Rounding half up becomes (2*num+den)/(2*den).
    assign seg_den  = hi_reg.ratio - prev_reg.ratio;
    assign seg_off  = z_reg - prev_reg.ratio;
    assign seg_rest = seg_den - seg_off;
    assign seg_flat = (hi_reg.ratio <= prev_reg.ratio) || (z_reg < prev_reg.ratio);

    assign num_near = irpz_pkg::NUM_W'(prev_reg.near * seg_rest)
                      + irpz_pkg::NUM_W'(hi_reg.near * seg_off);
    assign num_far  = irpz_pkg::NUM_W'(prev_reg.far * seg_rest)
                      + irpz_pkg::NUM_W'(hi_reg.far * seg_off);
    assign dvd_near = {num_near, 1'b0} + irpz_pkg::DVD_W'(seg_den);
    assign dvd_far  = {num_far, 1'b0} + irpz_pkg::DVD_W'(seg_den);
    assign dvs      = {seg_den, 1'b0};

    irpz_div u_div_near (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dvd_near),
        .divisor  (dvs),
        .quotient (quo_near),
        .done     (div_done_near)
    );

    irpz_div u_div_far (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dvd_far),
        .divisor  (dvs),
        .quotient (quo_far),
        .done     (div_done_far)
    );

    assign diff_near = (cur_near_reg > res_near_reg) ? (cur_near_reg - res_near_reg)
                                                     : (res_near_reg - cur_near_reg);
    assign diff_far  = (cur_far_reg > res_far_reg) ? (cur_far_reg - res_far_reg)
                                                   : (res_far_reg - cur_far_reg);

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        z_next        = z_reg;
        cur_near_next = cur_near_reg;
        cur_far_next  = cur_far_reg;
        prev_next     = prev_reg;
        hi_next       = hi_reg;
        res_near_next = res_near_reg;
        res_far_next  = res_far_reg;
        ram_raddr     = '0;
        div_start     = 1'b0;
        out_load      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (item_acc && is_query)
                begin
                    z_next        = item.data.zoom_ratio;
                    cur_near_next = item.data.current_near;
                    cur_far_next  = item.data.current_far;
                    res_near_next = '0;
                    res_far_next  = '0;
                    state_next    = S_EMIT;
                    if (night_reg)
                    begin
                        if (use_table)
                        begin
                            // The first breakpoint is being read already.
                            if (pcount_reg != '0)
                            begin
                                state_next = S_RD0;
                            end
                        end
                        else if (manual_reg)
                        begin
                            res_near_next = irpz_pkg::sat_duty(man_near_reg);
                            res_far_next  = irpz_pkg::sat_duty(man_far_reg);
                        end
                    end
                end
            end
            S_RD0:
            begin
                // Zoom at or below the first breakpoint clamps to it.
                if (z_reg <= ram_pt.ratio)
                begin
                    res_near_next = irpz_pkg::sat_duty(ram_pt.near);
                    res_far_next  = irpz_pkg::sat_duty(ram_pt.far);
                    state_next    = S_EMIT;
                end
                else
                begin
                    prev_next  = ram_pt;
                    ram_raddr  = last_idx;
                    state_next = S_RDLAST;
                end
            end
            S_RDLAST:
            begin
                // Zoom at or above the last breakpoint clamps to it.
                if (z_reg >= ram_pt.ratio)
                begin
                    res_near_next = irpz_pkg::sat_duty(ram_pt.near);
                    res_far_next  = irpz_pkg::sat_duty(ram_pt.far);
                    state_next    = S_EMIT;
                end
                else
                begin
                    ram_raddr  = AW'(1);
                    idx_next   = AW'(1);
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // The first breakpoint above the zoom closes the segment; the
                // last one in use closes it when none is found.
                if ((ram_pt.ratio > z_reg) || (idx_reg == last_idx))
                begin
                    hi_next    = ram_pt;
                    state_next = S_MUL;
                end
                else
                begin
                    prev_next  = ram_pt;
                    idx_next   = idx_reg + 1'b1;
                    ram_raddr  = idx_reg + 1'b1;
                end
            end
            S_MUL:
            begin
                // An empty or reversed segment gives the lower point.
                if (seg_flat)
                begin
                    res_near_next = irpz_pkg::sat_duty(prev_reg.near);
                    res_far_next  = irpz_pkg::sat_duty(prev_reg.far);
                    state_next    = S_EMIT;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done_near)
                begin
                    res_near_next = irpz_pkg::sat_duty(quo_near);
                    res_far_next  = irpz_pkg::sat_duty(quo_far);
                    state_next    = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_load)
        begin
            out_valid_next            = 1'b1;
            out_data_next.near_duty   = res_near_reg;
            out_data_next.far_duty    = res_far_reg;
            out_data_next.near_update = (diff_near >= deadband_reg);
            out_data_next.far_update  = (diff_far >= deadband_reg);
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        z_reg        <= z_next;
        cur_near_reg <= cur_near_next;
        cur_far_reg  <= cur_far_next;
        prev_reg     <= prev_next;
        hi_reg       <= hi_next;
        res_near_reg <= res_near_next;
        res_far_reg  <= res_far_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            night_reg    <= 1'b0;
            auto_reg     <= 1'b1;
            follow_reg   <= 1'b0;
            manual_reg   <= 1'b0;
            man_near_reg <= '0;
            man_far_reg  <= '0;
            pcount_reg   <= '0;
            deadband_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                irpz_pkg::CFG_NIGHT_ENABLE:       night_reg    <= cfg.data[0];
                irpz_pkg::CFG_AUTO_FOLLOW_ENABLE: auto_reg     <= cfg.data[0];
                irpz_pkg::CFG_FOLLOW_ACTIVE:      follow_reg   <= cfg.data[0];
                irpz_pkg::CFG_MANUAL_VALID:       manual_reg   <= cfg.data[0];
                irpz_pkg::CFG_MANUAL_NEAR:        man_near_reg <= cfg.data;
                irpz_pkg::CFG_MANUAL_FAR:         man_far_reg  <= cfg.data;
                irpz_pkg::CFG_POINT_COUNT:
                    pcount_reg <= cfg.data[irpz_pkg::PCOUNT_W-1:0];
                irpz_pkg::CFG_DEADBAND:           deadband_reg <= cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

endmodule

[sv/irpz_checker.sv]
// Port-level checker for the IR PWM zoom interpolator, bound to the top.
// Depends on irpz_pkg and assert_macros.svh.
`include "assert_macros.svh"

module irpz_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              item_valid,
    input logic              item_ready,
    input logic              item_kind,
    input logic              result_valid,
    input logic              result_ready,
    input irpz_pkg::result_t result_data
);

    // A stalled result beat holds its value.
    `ASSERT_RST(a_result_hold, clk, rst_n, result_valid && !result_ready |=> result_valid && $stable(result_data))

    // A query keeps the block busy for at least the next cycle.
    `ASSERT_RST(a_query_busy, clk, rst_n, item_valid && item_ready && item_kind == irpz_pkg::KIND_QUERY |=> !item_ready)

    // A fresh result is only shown after the block was busy with a query.
    `ASSERT_RST(a_result_after_work, clk, rst_n, $rose(result_valid) |-> !$past(item_ready))

    // Duties never leave the percent range.
    `ASSERT_ALWAYS(a_duty_range, clk, result_valid |-> result_data.near_duty <= irpz_pkg::DUTY_MAX && result_data.far_duty <= irpz_pkg::DUTY_MAX)

endmodule

bind ir_pwm_zoom_interpolator irpz_checker u_irpz_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .item_kind    (item.data.kind),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_data  (result.data)
);
